[hdl/erm_pkg.sv]
// Package for the Euler rotation matrix builder: widths, CORDIC table,
// shared types and fixed-point helpers. No dependencies.
`default_nettype none
package erm_pkg;
    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int WORK_FRAC    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int OUT_BITS     = 16;
    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;

    // CORDIC working word (Q30 plus sign and growth)
    typedef logic signed [33:0] work_t;
    typedef logic signed [OUT_BITS-1:0] elem_t;

    // Data handed from one CORDIC cell to the next, one angle
    typedef struct packed {
        work_t       x;
        work_t       y;
        work_t       z;
        logic [1:0]  quad;
    } rot_t;

    // Three angles travel together through the cell chain
    typedef struct packed {
        rot_t p;
        rot_t r;
        rot_t w;
    } trio_t;

    function automatic work_t atan_entry(input logic [4:0] idx);
        work_t t;
        t = '0;
        unique case (idx)
            5'd0:  t = 34'sh020000000;
            5'd1:  t = 34'sh012E4051D;
            5'd2:  t = 34'sh009FB385B;
            5'd3:  t = 34'sh0051111D4;
            5'd4:  t = 34'sh0028B0D43;
            5'd5:  t = 34'sh00145D7E1;
            5'd6:  t = 34'sh000A2F61E;
            5'd7:  t = 34'sh000517C55;
            5'd8:  t = 34'sh00028BE53;
            5'd9:  t = 34'sh000145F2E;
            5'd10: t = 34'sh0000A2F98;
            5'd11: t = 34'sh0000517CC;
            5'd12: t = 34'sh000028BE6;
            5'd13: t = 34'sh0000145F3;
            5'd14: t = 34'sh000000A2F9;
            5'd15: t = 34'sh00000517C;
            5'd16: t = 34'sh0000028BE;
            5'd17: t = 34'sh00000145F;
            5'd18: t = 34'sh000000A2F;
            5'd19: t = 34'sh000000517;
            5'd20: t = 34'sh00000028B;
            5'd21: t = 34'sh000000145;
            5'd22: t = 34'sh0000000A2;
            5'd23: t = 34'sh000000051;
            5'd24: t = 34'sh000000028;
            5'd25: t = 34'sh000000014;
            5'd26: t = 34'sh00000000A;
            5'd27: t = 34'sh000000005;
            5'd28: t = 34'sh000000002;
            5'd29: t = 34'sh000000001;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Q30 product with round half up, floor shift
    function automatic work_t qmul(input work_t a, input work_t b);
        logic signed [67:0] p;
        p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
        return work_t'(p >>> WORK_FRAC);
    endfunction

    // Q30 to saturated Q1.FRAC_BITS output field
    function automatic elem_t to_out(input work_t v);
        work_t r;
        work_t lim;
        lim = work_t'(1) <<< FRAC_BITS;
        r = (v + (work_t'(1) <<< (WORK_FRAC - FRAC_BITS - 1))) >>> (WORK_FRAC - FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return elem_t'(r);
    endfunction
endpackage
`default_nettype wire

[hdl/euler_rotation_matrix_build_core.sv]
// Top level of the Euler rotation matrix builder.
// Depends on erm_pkg, erm_cell, erm_matrix.
// Takes one item per cycle while the output is not stalled and returns
// M = Rz(yaw)*Rx(pitch)*Ry(roll) in signed Q1.14 through one input stage, a
// chain of 30 CORDIC cells and three product stages. The whole pipe advances
// while the output register is empty or being taken, so stall stops it in place.
`default_nettype none
module euler_rotation_matrix_build_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] pitch_angle,
    input  wire logic [15:0] roll_angle,
    input  wire logic [15:0] yaw_angle,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      m00,
    output logic [15:0]      m01,
    output logic [15:0]      m02,
    output logic [15:0]      m10,
    output logic [15:0]      m11,
    output logic [15:0]      m12,
    output logic [15:0]      m20,
    output logic [15:0]      m21,
    output logic [15:0]      m22
);
    import erm_pkg::*;

    logic   advance;
    logic   v_in_reg;
    trio_t  d_in_reg;
    trio_t  d_in_next;
    logic   cv [CORDIC_STEPS+1];
    trio_t  cd [CORDIC_STEPS+1];

    function automatic rot_t seed(input logic [ANGLE_BITS-1:0] a);
        rot_t        o;
        logic [31:0] sh;
        sh     = {a, {(32-ANGLE_BITS){1'b0}}} + 32'h2000_0000;
        o.quad = sh[31:30];
        o.x    = INV_GAIN;
        o.y    = '0;
        o.z    = work_t'($signed({1'b0, sh[29:0]})) - 34'sh020000000;
        return o;
    endfunction

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        d_in_next.p = seed(pitch_angle[ANGLE_BITS-1:0]);
        d_in_next.r = seed(roll_angle[ANGLE_BITS-1:0]);
        d_in_next.w = seed(yaw_angle[ANGLE_BITS-1:0]);
    end

    // Hold input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_in_reg <= 1'b0;
        else if (advance)
            v_in_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            d_in_reg <= d_in_next;
    end

    assign cv[0] = v_in_reg;
    assign cd[0] = d_in_reg;

    // Chain of CORDIC cells
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        erm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .step      (5'(g)),
            .in_valid  (cv[g]),
            .in_data   (cd[g]),
            .out_valid (cv[g+1]),
            .out_data  (cd[g+1])
        );
    end

    erm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (cv[CORDIC_STEPS]),
        .in_data   (cd[CORDIC_STEPS]),
        .out_valid (out_valid),
        .m00 (m00), .m01 (m01), .m02 (m02),
        .m10 (m10), .m11 (m11), .m12 (m12),
        .m20 (m20), .m21 (m21), .m22 (m22)
    );
endmodule
`default_nettype wire

[hdl/erm_cell.sv]
// One CORDIC rotation cell for three angles; fixed step index set by input.
// Depends on erm_pkg.
`default_nettype none
module erm_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic [4:0]     step,
    input  wire logic           in_valid,
    input  erm_pkg::trio_t      in_data,
    output logic                out_valid,
    output erm_pkg::trio_t      out_data
);
    import erm_pkg::*;

    logic   valid_reg;
    trio_t  data_reg;
    trio_t  data_next;
    work_t  ang;

    function automatic rot_t rotate(input rot_t a, input logic [4:0] i, input work_t t);
        rot_t  o;
        work_t dx;
        work_t dy;
        o  = a;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (a.z >= 0)
        begin
            o.x = a.x - dx;
            o.y = a.y + dy;
            o.z = a.z - t;
        end
        else
        begin
            o.x = a.x + dx;
            o.y = a.y - dy;
            o.z = a.z + t;
        end
        return o;
    endfunction

    // Rotate all three angles by one step
    always_comb
    begin
        ang         = atan_entry(step);
        data_next.p = rotate(in_data.p, step, ang);
        data_next.r = rotate(in_data.r, step, ang);
        data_next.w = rotate(in_data.w, step, ang);
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

[hdl/erm_matrix.sv]
// Matrix product stages: quadrant map, products, output rounding.
// Depends on erm_pkg.
`default_nettype none
module erm_matrix (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           in_valid,
    input  erm_pkg::trio_t      in_data,
    output logic                out_valid,
    output erm_pkg::elem_t      m00,
    output erm_pkg::elem_t      m01,
    output erm_pkg::elem_t      m02,
    output erm_pkg::elem_t      m10,
    output erm_pkg::elem_t      m11,
    output erm_pkg::elem_t      m12,
    output erm_pkg::elem_t      m20,
    output erm_pkg::elem_t      m21,
    output erm_pkg::elem_t      m22
);
    import erm_pkg::*;

    logic [2:0] valid_reg;
    work_t cp_reg, sp_reg, cr_reg, sr_reg, cy_reg, sy_reg;
    work_t cp_b, sp_b, cr_b, sr_b, cy_b, sy_b, spsr_reg, spcr_reg;
    elem_t o_reg [9];
    work_t cp_n, sp_n, cr_n, sr_n, cy_n, sy_n;

    function automatic logic [67:0] qmap(input rot_t a);
        work_t c;
        work_t s;
        unique case (a.quad)
            2'd0: begin c = a.x;  s = a.y;  end
            2'd1: begin c = -a.y; s = a.x;  end
            2'd2: begin c = -a.x; s = -a.y; end
            default: begin c = a.y; s = -a.x; end
        endcase
        return {c, s};
    endfunction

    always_comb
    begin
        {cp_n, sp_n} = qmap(in_data.p);
        {cr_n, sr_n} = qmap(in_data.r);
        {cy_n, sy_n} = qmap(in_data.w);
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    // Stage 1 sin/cos, stage 2 pitch-roll products, stage 3 elements
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cp_reg <= cp_n; sp_reg <= sp_n; cr_reg <= cr_n;
            sr_reg <= sr_n; cy_reg <= cy_n; sy_reg <= sy_n;
            cp_b <= cp_reg; sp_b <= sp_reg; cr_b <= cr_reg;
            sr_b <= sr_reg; cy_b <= cy_reg; sy_b <= sy_reg;
            spsr_reg <= qmul(sp_reg, sr_reg);
            spcr_reg <= qmul(sp_reg, cr_reg);
            o_reg[0] <= to_out(qmul(cy_b, cr_b) + qmul(sy_b, spsr_reg));
            o_reg[1] <= to_out(-qmul(sy_b, cp_b));
            o_reg[2] <= to_out(-qmul(cy_b, sr_b) + qmul(sy_b, spcr_reg));
            o_reg[3] <= to_out(qmul(sy_b, cr_b) - qmul(cy_b, spsr_reg));
            o_reg[4] <= to_out(qmul(cy_b, cp_b));
            o_reg[5] <= to_out(-qmul(sy_b, sr_b) - qmul(cy_b, spcr_reg));
            o_reg[6] <= to_out(qmul(cp_b, sr_b));
            o_reg[7] <= to_out(sp_b);
            o_reg[8] <= to_out(qmul(cp_b, cr_b));
        end
    end

    assign out_valid = valid_reg[2];
    assign m00 = o_reg[0];
    assign m01 = o_reg[1];
    assign m02 = o_reg[2];
    assign m10 = o_reg[3];
    assign m11 = o_reg[4];
    assign m12 = o_reg[5];
    assign m20 = o_reg[6];
    assign m21 = o_reg[7];
    assign m22 = o_reg[8];
endmodule
`default_nettype wire
